// ===== design/pse_pkg.sv =====
package pse_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DATA_W      = 32;
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   // token kinds
   localparam logic [2:0] FUNC_PUSH = 3'd0;
   localparam logic [2:0] FUNC_ADD  = 3'd1;
   localparam logic [2:0] FUNC_SUB  = 3'd2;
   localparam logic [2:0] FUNC_MUL  = 3'd3;
   localparam logic [2:0] FUNC_DIV  = 3'd4;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_DIVZERO   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH,
      S_MUL,
      S_DIV,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [30:0] operand_value;
      logic        last;
   } pse_req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
   } pse_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic    capture;
      logic    push;
      logic    set_err;
      err_type err_code;
      logic    addsub_wr;
      logic    mul_wr;
      logic    div_start;
      logic    div_wr;
      logic    emit;
   } pse_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] func;
      logic       last;
      logic       err_set;
      logic       depth_full;
      logic       depth_lt2;
      logic       rhs_zero;
      logic       div_done;
      logic       out_free;
   } pse_sts_type;

endpackage

// ===== design/postfix_stack_evaluator_core.sv =====
// one token at a time: push runs IDLE, EXEC, FINISH; add/sub adds FETCH; multiply
// adds FETCH and MUL; divide adds FETCH and DIV (radix-2, one quotient bit per cycle)
// a last token waits in FINISH only while an earlier word is still stalled; its result
// word appears the cycle after it completes and the next token is taken while it waits
// reset is synchronous: stack empty, status ok, no result pending;
// stack memory contents are not cleared
module postfix_stack_evaluator_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pse_pkg::pse_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pse_pkg::pse_rsp_type rsp_word
);

   import pse_pkg::*;

   pse_cmd_type cmd;
   pse_sts_type sts;

   // sequencer
   pse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stack, arithmetic and result register
   pse_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== design/pse_ram.sv =====
module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pse_ctrl.sv =====
module pse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pse_pkg::pse_sts_type sts,
   output pse_pkg::pse_cmd_type cmd
);

   import pse_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.err_code = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            if (!sts.err_set) begin
               if (sts.func == FUNC_PUSH) begin
                  if (sts.depth_full) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ST_OVERFLOW;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end else if (sts.func == FUNC_ADD || sts.func == FUNC_SUB ||
                            sts.func == FUNC_MUL || sts.func == FUNC_DIV) begin
                  if (sts.depth_lt2) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ST_UNDERFLOW;
                  end else begin
                     // lhs read issued from depth-2, data next cycle
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_FETCH: begin
            case (sts.func)
               FUNC_ADD, FUNC_SUB: begin
                  cmd.addsub_wr = 1'b1;
                  state_in      = S_FINISH;
               end
               FUNC_MUL: begin
                  state_in = S_MUL;
               end
               default: begin
                  if (sts.rhs_zero) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ST_DIVZERO;
                     state_in     = S_FINISH;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
            endcase
         end
         S_MUL: begin
            cmd.mul_wr = 1'b1;
            state_in   = S_FINISH;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.div_wr = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!sts.last) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/pse_datapath.sv =====
module pse_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pse_pkg::pse_req_type req_word,
   input  pse_pkg::pse_cmd_type cmd,
   output pse_pkg::pse_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pse_pkg::pse_rsp_type rsp_word
);

   import pse_pkg::*;

   // captured token
   logic [2:0]        func_ff;
   logic [30:0]       operand_ff;
   logic              last_ff;

   // stack state: top held in a register, the rest in memory
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [DATA_W-1:0]  tos_ff, tos_in;
   err_type            err_ff, err_in;

   logic [DEPTH_W-1:0] depth_m1, depth_m2;
   logic               ram_wr_en;
   logic [DATA_W-1:0]  lhs;

   // multiplier and divider
   logic [DATA_W-1:0]    prod_ff;
   logic [DATA_W-1:0]    quot_ff, quot_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    divisor_ff, divisor_in;
   logic                 neg_ff, neg_in;
   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W:0]      rem_shift;
   logic [DATA_W:0]      rem_sub;
   logic [DATA_W-1:0]    quot_signed;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   pse_rsp_type rsp_ff, rsp_in;
   logic        out_free;

   assign depth_m1  = depth_ff - DEPTH_W'(1);
   assign depth_m2  = depth_ff - DEPTH_W'(2);
   assign ram_wr_en = cmd.push && (depth_ff != '0);

   pse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (depth_m1[ADDR_W-1:0]),
      .wr_data (tos_ff),
      .rd_addr (depth_m2[ADDR_W-1:0]),
      .rd_data (lhs)
   );

   // token capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_word.func;
         operand_ff <= req_word.operand_value;
         last_ff    <= req_word.last;
      end
   end

   // product registered before write-back
   always_ff @(posedge clock) begin
      prod_ff <= lhs * tos_ff;
   end

   // restoring divider on magnitudes, one quotient bit per cycle
   assign rem_shift   = {rem_ff, quot_ff[DATA_W-1]};
   assign rem_sub     = rem_shift - {1'b0, divisor_ff};
   assign quot_signed = neg_ff ? (DATA_W'(0) - quot_ff) : quot_ff;

   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      if (cmd.div_start) begin
         quot_in    = lhs[DATA_W-1] ? (DATA_W'(0) - lhs) : lhs;
         divisor_in = tos_ff[DATA_W-1] ? (DATA_W'(0) - tos_ff) : tos_ff;
         neg_in     = lhs[DATA_W-1] ^ tos_ff[DATA_W-1];
         rem_in     = '0;
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_W'(DATA_W - 1);
      end else if (busy_ff) begin
         if (!rem_sub[DATA_W]) begin
            rem_in  = rem_sub[DATA_W-1:0];
            quot_in = {quot_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[DATA_W-1:0];
            quot_in = {quot_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
      cnt_ff     <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // stack and status update
   always_comb begin
      depth_in = depth_ff;
      tos_in   = tos_ff;
      err_in   = err_ff;
      if (cmd.set_err && err_ff == ST_OK) begin
         err_in = cmd.err_code;
      end
      if (cmd.push) begin
         tos_in   = {1'b0, operand_ff};
         depth_in = depth_ff + DEPTH_W'(1);
      end
      if (cmd.addsub_wr) begin
         tos_in   = (func_ff == FUNC_SUB) ? (lhs - tos_ff) : (lhs + tos_ff);
         depth_in = depth_m1;
      end
      if (cmd.mul_wr) begin
         tos_in   = prod_ff;
         depth_in = depth_m1;
      end
      if (cmd.div_wr) begin
         tos_in   = quot_signed;
         depth_in = depth_m1;
      end
      if (cmd.emit) begin
         depth_in = '0;
         err_in   = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         err_ff   <= ST_OK;
      end else begin
         depth_ff <= depth_in;
         err_ff   <= err_in;
      end
   end

   // result word
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (err_ff != ST_OK) begin
            rsp_in.result_value = '0;
            rsp_in.status       = err_ff;
         end else if (depth_ff == '0) begin
            rsp_in.result_value = '0;
            rsp_in.status       = ST_UNDERFLOW;
         end else begin
            rsp_in.result_value = tos_ff;
            rsp_in.status       = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // status to controller
   assign sts.func       = func_ff;
   assign sts.last       = last_ff;
   assign sts.err_set    = (err_ff != ST_OK);
   assign sts.depth_full = (depth_ff == DEPTH_W'(STACK_DEPTH));
   assign sts.depth_lt2  = (depth_ff < DEPTH_W'(2));
   assign sts.rhs_zero   = (tos_ff == '0);
   assign sts.div_done   = !busy_ff;
   assign sts.out_free   = out_free;

endmodule
